// ----- design/e2q_pkg.sv -----
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, fixed-point constants and the arctangent table used by the
// Euler-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

    // Default number of CORDIC iterations.
    localparam int CORDIC_STEPS = 28;

    // Width of the internal CORDIC datapath (Q2.30 with guard bits).
    localparam int CW = 34;

    typedef logic signed [CW-1:0] t_cval;
    typedef logic signed [31:0]   t_word;

    // CORDIC gain 0.60725293 in Q2.30.
    localparam t_cval GAIN_Q30    = 34'sd652032874;
    // Pi and pi/2 in Q2.30.
    localparam t_cval PI_Q30      = 34'sd3373259426;
    localparam t_cval HALF_PI_Q30 = 34'sd1686629713;
    // One in Q1.30 and half an LSB of a Q60 to Q30 rounding.
    localparam t_cval ONE_Q30     = 34'sd1073741824;
    localparam longint HALF_LSB   = 64'sd536870912;

    // atan(2^-i) in Q2.30, rounded half up.
    function automatic t_cval atan_q30(input int i);
        t_cval v;
        v = '0;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            31: v = 34'sd1;
            default: v = 34'sd1 <<< (30 - i);
        endcase
        return v;
    endfunction

endpackage

// ----- design/e2q_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// e2q_cordic_stage
// One registered rotation-mode CORDIC iteration with a fixed shift.
// ----------------------------------------------------------------------------
module e2q_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  e2q_pkg::t_cval      i_x,
    input  e2q_pkg::t_cval      i_y,
    input  e2q_pkg::t_cval      i_z,
    input  logic                i_flip,
    output logic                o_valid,
    output e2q_pkg::t_cval      o_x,
    output e2q_pkg::t_cval      o_y,
    output e2q_pkg::t_cval      o_z,
    output logic                o_flip
);

    localparam e2q_pkg::t_cval ATAN = e2q_pkg::atan_q30(SHIFT);

    logic           r_valid;
    e2q_pkg::t_cval r_x, r_y, r_z;
    logic           r_flip;
    e2q_pkg::t_cval n_x, n_y, n_z;

    // Rotate towards zero residual angle; z at zero counts as positive.
    always_comb begin
        if (!i_z[e2q_pkg::CW-1]) begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_z = i_z + ATAN;
        end
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_flip <= i_flip;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flip  = r_flip;

endmodule

// ----- design/e2q_sincos.sv -----
// ----------------------------------------------------------------------------
// e2q_sincos
// Halves an angle, reduces it into [-pi/2, pi/2] and runs a pipelined CORDIC
// to give the cosine and sine of the half angle in Q1.30.
// ----------------------------------------------------------------------------
module e2q_sincos #(
    parameter int STEPS = e2q_pkg::CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [31:0]  i_angle,
    output logic                o_valid,
    output e2q_pkg::t_word      o_cos,
    output e2q_pkg::t_word      o_sin
);

    e2q_pkg::t_cval a_half;
    e2q_pkg::t_cval n_z;
    logic           n_flip;

    logic           v_s [0:STEPS];
    e2q_pkg::t_cval x_s [0:STEPS];
    e2q_pkg::t_cval y_s [0:STEPS];
    e2q_pkg::t_cval z_s [0:STEPS];
    logic           f_s [0:STEPS];

    logic           r_v0;
    e2q_pkg::t_cval r_z0;
    logic           r_flip0;
    e2q_pkg::t_cval c_fin, s_fin;

    // Q3.28 times two gives the half angle in Q2.30 exactly.
    assign a_half = $signed({i_angle[31], i_angle, 1'b0});

    // Quadrant reduction by one step of pi.
    always_comb begin
        n_flip = 1'b0;
        n_z    = a_half;
        if (a_half > e2q_pkg::HALF_PI_Q30) begin
            n_z    = a_half - e2q_pkg::PI_Q30;
            n_flip = 1'b1;
        end else if (a_half < -e2q_pkg::HALF_PI_Q30) begin
            n_z    = a_half + e2q_pkg::PI_Q30;
            n_flip = 1'b1;
        end
    end

    // Entry register after the reduction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z0    <= n_z;
        r_flip0 <= n_flip;
    end

    assign v_s[0] = r_v0;
    assign x_s[0] = e2q_pkg::GAIN_Q30;
    assign y_s[0] = '0;
    assign z_s[0] = r_z0;
    assign f_s[0] = r_flip0;

    // One registered stage per iteration.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        e2q_cordic_stage #(
            .SHIFT (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_s[k]),
            .i_x     (x_s[k]),
            .i_y     (y_s[k]),
            .i_z     (z_s[k]),
            .i_flip  (f_s[k]),
            .o_valid (v_s[k+1]),
            .o_x     (x_s[k+1]),
            .o_y     (y_s[k+1]),
            .o_z     (z_s[k+1]),
            .o_flip  (f_s[k+1])
        );
    end

    // Undo the reduction by negating both results.
    assign c_fin = f_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
    assign s_fin = f_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];

    assign o_valid = v_s[STEPS];
    assign o_cos   = c_fin[31:0];
    assign o_sin   = s_fin[31:0];

`ifndef NO_ASSERTIONS
    // The reduced angle always lies within the CORDIC convergence range.
    a_reduced_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 |-> (r_z0 <= e2q_pkg::HALF_PI_Q30) && (r_z0 >= -e2q_pkg::HALF_PI_Q30))
        else $error("reduced angle outside [-pi/2, pi/2]");
`endif

endmodule

// ----- design/e2q_combine.sv -----
// ----------------------------------------------------------------------------
// e2q_combine
// Forms the ZYX quaternion from the half-angle sines and cosines in four
// register stages: pair products, rounding, triple products, sum and clamp.
// ----------------------------------------------------------------------------
module e2q_combine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  e2q_pkg::t_word      i_cr,
    input  e2q_pkg::t_word      i_sr,
    input  e2q_pkg::t_word      i_cp,
    input  e2q_pkg::t_word      i_sp,
    input  e2q_pkg::t_word      i_cy,
    input  e2q_pkg::t_word      i_sy,
    output logic                o_valid,
    output e2q_pkg::t_word      o_w,
    output e2q_pkg::t_word      o_x,
    output e2q_pkg::t_word      o_y,
    output e2q_pkg::t_word      o_z
);

    logic [3:0] r_v;

    logic signed [63:0] r_ccp, r_ssp, r_scp, r_csp;
    e2q_pkg::t_word     r_cy1, r_sy1, r_cy2, r_sy2;
    e2q_pkg::t_cval     r_rcc, r_rss, r_rsc, r_rcs;
    logic signed [65:0] r_p [0:7];
    e2q_pkg::t_word     r_w, r_x, r_y, r_z;

    logic signed [66:0] n_sum [0:3];
    e2q_pkg::t_word     n_out [0:3];

    // Round a Q60 product half up to Q30.
    function automatic e2q_pkg::t_cval rnd64(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + e2q_pkg::HALF_LSB) >>> 30;
        return t[e2q_pkg::CW-1:0];
    endfunction

    // Round a Q60 sum half up and clamp to plus or minus one.
    function automatic e2q_pkg::t_word fin(input logic signed [66:0] v);
        logic signed [66:0] t;
        t = (v + 67'(e2q_pkg::HALF_LSB)) >>> 30;
        if (t > 67'(e2q_pkg::ONE_Q30)) begin
            t = 67'(e2q_pkg::ONE_Q30);
        end else if (t < -67'(e2q_pkg::ONE_Q30)) begin
            t = -67'(e2q_pkg::ONE_Q30);
        end
        return t[31:0];
    endfunction

    // Valid bits run alongside the four data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // Stage one: roll and pitch pair products, yaw delayed.
    always_ff @(posedge i_clk) begin
        r_ccp <= 64'(i_cr) * 64'(i_cp);
        r_ssp <= 64'(i_sr) * 64'(i_sp);
        r_scp <= 64'(i_sr) * 64'(i_cp);
        r_csp <= 64'(i_cr) * 64'(i_sp);
        r_cy1 <= i_cy;
        r_sy1 <= i_sy;
    end

    // Stage two: round the pair products to Q30.
    always_ff @(posedge i_clk) begin
        r_rcc <= rnd64(r_ccp);
        r_rss <= rnd64(r_ssp);
        r_rsc <= rnd64(r_scp);
        r_rcs <= rnd64(r_csp);
        r_cy2 <= r_cy1;
        r_sy2 <= r_sy1;
    end

    // Stage three: triple products.
    always_ff @(posedge i_clk) begin
        r_p[0] <= 66'(r_rcc) * 66'(r_cy2);
        r_p[1] <= 66'(r_rss) * 66'(r_sy2);
        r_p[2] <= 66'(r_rsc) * 66'(r_cy2);
        r_p[3] <= 66'(r_rcs) * 66'(r_sy2);
        r_p[4] <= 66'(r_rcs) * 66'(r_cy2);
        r_p[5] <= 66'(r_rsc) * 66'(r_sy2);
        r_p[6] <= 66'(r_rcc) * 66'(r_sy2);
        r_p[7] <= 66'(r_rss) * 66'(r_cy2);
    end

    // Stage four: sum, round and saturate each component.
    always_comb begin
        n_sum[0] = 67'(r_p[0]) + 67'(r_p[1]);
        n_sum[1] = 67'(r_p[2]) - 67'(r_p[3]);
        n_sum[2] = 67'(r_p[4]) + 67'(r_p[5]);
        n_sum[3] = 67'(r_p[6]) - 67'(r_p[7]);
        for (int k = 0; k < 4; k++) begin
            n_out[k] = fin(n_sum[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_out[0];
        r_x <= n_out[1];
        r_y <= n_out[2];
        r_z <= n_out[3];
    end

    assign o_valid = r_v[3];
    assign o_w     = r_w;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

`ifndef NO_ASSERTIONS
    // Saturation keeps every delivered component within plus or minus one.
    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> (r_w <= 32'sd1073741824) && (r_w >= -32'sd1073741824))
        else $error("scalar component beyond unit range");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> (r_x <= 32'sd1073741824) && (r_x >= -32'sd1073741824))
        else $error("x component beyond unit range");
`endif

endmodule

// ----- design/euler_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles (Q3.28 radians) to a saturated Q1.30 quaternion.
// ----------------------------------------------------------------------------
// The block takes one set of angle words per clock and never raises busy. Each
// set yields one result, strobed by o_valid for a single cycle, after it has
// passed one reduction stage, one register per CORDIC iteration and four
// product stages. The receiver cannot stall, so it must take every result in
// the cycle that it is strobed.
module euler_to_quaternion #(
    parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_roll_angle,
    input  logic signed [31:0]  i_pitch_angle,
    input  logic signed [31:0]  i_yaw_angle,
    output logic                o_valid,
    output logic signed [31:0]  o_scalar_part,
    output logic signed [31:0]  o_vector_x,
    output logic signed [31:0]  o_vector_y,
    output logic signed [31:0]  o_vector_z
);

    logic           take;
    logic           v_sc;
    e2q_pkg::t_word cr, sr, cp, sp, cy, sy;

    // The pipeline accepts a word on every cycle.
    assign busy = 1'b0;
    assign take = start & ~busy;

    // One sine and cosine pipeline per axis; they run in lock step.
    e2q_sincos #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (take),
        .i_angle (i_roll_angle),
        .o_valid (v_sc),
        .o_cos   (cr),
        .o_sin   (sr)
    );

    e2q_sincos #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (take),
        .i_angle (i_pitch_angle),
        .o_valid (),
        .o_cos   (cp),
        .o_sin   (sp)
    );

    e2q_sincos #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (take),
        .i_angle (i_yaw_angle),
        .o_valid (),
        .o_cos   (cy),
        .o_sin   (sy)
    );

    // Quaternion products, rounding and saturation.
    e2q_combine u_comb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_sc),
        .i_cr    (cr),
        .i_sr    (sr),
        .i_cp    (cp),
        .i_sp    (sp),
        .i_cy    (cy),
        .i_sy    (sy),
        .o_valid (o_valid),
        .o_w     (o_scalar_part),
        .o_x     (o_vector_x),
        .o_y     (o_vector_y),
        .o_z     (o_vector_z)
    );

endmodule
